>>> rtl/tclp_pkg.sv
package tclp_pkg;

    localparam int MaxNodes = 1024;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int CntW     = 11;
    localparam logic [CntW-1:0] CntMax = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_A,
        S_LOAD_B,
        S_CHECK,
        S_SEED,
        S_PEEL_RD,
        S_PEEL_LEAF,
        S_PEEL_PAR,
        S_FINAL,
        S_OUT0,
        S_OUT1,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic             mode;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic [NodeW-1:0] center_node;
        logic             last;
        logic             error;
    } t_out_item;

endpackage

>>> rtl/tclp_if.sv
interface tclp_in_if
    import tclp_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tclp_out_if
    import tclp_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tclp_store.sv
// node store: degree and neighbor xor per node, one access a cycle, read data registered
module tclp_store
    import tclp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [NodeW-1:0] i_addr,
    input  logic [CntW-1:0]  i_wdeg,
    input  logic [NodeW-1:0] i_wxor,
    output logic [CntW-1:0]  o_rdeg,
    output logic [NodeW-1:0] o_rxor
);
    logic [CntW-1:0]  r_deg [MaxNodes];
    logic [NodeW-1:0] r_xor [MaxNodes];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_deg[i_addr] <= i_wdeg;
            r_xor[i_addr] <= i_wxor;
        end
        o_rdeg <= r_deg[i_addr];
        o_rxor <= r_xor[i_addr];
    end
endmodule

>>> rtl/tclp_queue.sv
// leaf queue memory, one write port and one registered read port
module tclp_queue
    import tclp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [NodeW-1:0] i_waddr,
    input  logic [NodeW-1:0] i_wdata,
    input  logic [NodeW-1:0] i_raddr,
    output logic [NodeW-1:0] o_rdata
);
    logic [NodeW-1:0] r_mem [MaxNodes];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/tree_center_leaf_peeler.sv
// Tree center finder. An edge item (mode 0) makes a read-modify-write of each
// endpoint through the single port of the node store. A run item (mode 1) scans
// all 1024 degree entries (leaves below node_count are queued, nonzero degrees
// at or above it flag an error), peels the queued leaves layer by layer (a leaf
// whose degree already fell to zero is skipped), closes the peel, fetches the
// survivors, sends the results at one transfer per cycle unless the sink stalls,
// then runs a clearing pass of the node store. The same clearing pass runs after
// reset before the first item is taken. Results of a run are 1 or 2 transfers,
// with error set and center 0 when the edges do not form a tree of node_count
// nodes.
module tree_center_leaf_peeler
    import tclp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            cfg_we,
    input  logic [CntW-1:0] cfg_wdata,
    tclp_in_if.sink         in_ch,
    tclp_out_if.source      out_ch
);
    t_state r_state, n_state;
    logic [CntW-1:0]  r_ncount, r_edges, n_edges, r_rem, n_rem;
    logic             r_fault, n_fault, r_bad, n_bad;
    logic [NodeW-1:0] r_a, n_a, r_b, n_b;
    logic [CntW-1:0]  r_idx, n_idx;        // scan / clear index
    logic [CntW-1:0]  r_head, n_head, r_tail, n_tail, r_lend, n_lend;
    logic [NodeW-1:0] r_leaf, n_leaf, r_c0, n_c0, r_c1, n_c1;
    logic             r_ph, n_ph;          // sub-phase of steps that read, then act

    logic             s_we;
    logic [NodeW-1:0] s_addr, s_wxor, s_rxor;
    logic [CntW-1:0]  s_wdeg, s_rdeg;
    logic             q_we;
    logic [NodeW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

    tclp_store u_store (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdeg(s_wdeg),
        .i_wxor(s_wxor), .o_rdeg(s_rdeg), .o_rxor(s_rxor)
    );

    tclp_queue u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ncount <= CntW'(1);
        else if (cfg_we) r_ncount <= cfg_wdata;
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_edges <= '0;
            r_fault <= 1'b0;
            r_idx   <= '0;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edges <= n_edges;
            r_fault <= n_fault;
            r_idx   <= n_idx;
            r_ph    <= n_ph;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_bad  <= n_bad;
        r_a    <= n_a;
        r_b    <= n_b;
        r_rem  <= n_rem;
        r_head <= n_head;
        r_tail <= n_tail;
        r_lend <= n_lend;
        r_leaf <= n_leaf;
        r_c0   <= n_c0;
        r_c1   <= n_c1;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_edges = r_edges; n_fault = r_fault; n_idx = r_idx;
        n_ph = r_ph; n_bad = r_bad; n_a = r_a; n_b = r_b; n_rem = r_rem;
        n_head = r_head; n_tail = r_tail; n_lend = r_lend; n_leaf = r_leaf;
        n_c0 = r_c0; n_c1 = r_c1;
        s_we = 1'b0; s_addr = '0; s_wdeg = '0; s_wxor = '0;
        q_we = 1'b0; q_waddr = r_tail[NodeW-1:0]; q_wdata = '0;
        q_raddr = r_head[NodeW-1:0];
        in_ch.ready = 1'b0;
        out_ch.valid = 1'b0;
        out_ch.data = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ch.ready = 1'b1;
                s_addr = in_ch.data.node_a;
                if (in_ch.valid) begin
                    if (in_ch.data.mode) begin
                        n_bad = r_fault || r_ncount == '0 ||
                                r_ncount > CntW'(MaxNodes) ||
                                r_edges != r_ncount - CntW'(1);
                        n_idx = '0; n_ph = 1'b0; n_tail = '0; n_head = '0;
                        n_rem = r_ncount;
                        n_state = S_CHECK;
                    end else begin
                        n_a = in_ch.data.node_a;
                        n_b = in_ch.data.node_b;
                        if (r_edges != CntMax) n_edges = r_edges + CntW'(1);
                        n_state = S_LOAD_A;
                    end
                end
            end
            S_LOAD_A: begin
                // store read of a done; write a, b is read in S_LOAD_B
                s_we = 1'b1; s_addr = r_a;
                s_wdeg = (s_rdeg != CntMax) ? s_rdeg + CntW'(1) : s_rdeg;
                s_wxor = s_rxor ^ r_b;
                n_state = S_LOAD_B; n_ph = 1'b0;
            end
            S_LOAD_B: begin
                s_addr = r_b;
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    s_we = 1'b1;
                    s_wdeg = (s_rdeg != CntMax) ? s_rdeg + CntW'(1) : s_rdeg;
                    s_wxor = s_rxor ^ r_a;
                    n_ph = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                // scan all entries: out-of-range degree check and leaf seeding
                s_addr = r_idx[NodeW-1:0];
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_idx >= r_ncount && s_rdeg != '0) n_bad = 1'b1;
                    if (r_idx < r_ncount && s_rdeg == CntW'(1)) begin
                        q_we = 1'b1; q_wdata = r_idx[NodeW-1:0];
                        n_tail = r_tail + CntW'(1);
                    end
                    n_idx = r_idx + CntW'(1);
                    if (r_idx == CntW'(MaxNodes - 1)) begin
                        // head starts on a layer boundary
                        n_lend = '0;
                        n_state = S_SEED;
                    end
                end
            end
            S_SEED: begin
                if (r_bad || r_ncount == CntW'(1)) n_state = S_FINAL;
                else n_state = S_PEEL_RD;
            end
            S_PEEL_RD: begin
                // queue read issued at head; the stop test is made only between layers
                if (r_head == r_lend && !(r_head < r_tail && r_rem > CntW'(2))) begin
                    n_state = S_FINAL;
                end else begin
                    if (r_head == r_lend) n_lend = r_tail;
                    if (!r_ph) n_ph = 1'b1;
                    else begin
                        n_ph = 1'b0;
                        n_leaf = q_rdata;
                        n_state = S_PEEL_LEAF;
                    end
                end
            end
            S_PEEL_LEAF: begin
                s_addr = r_leaf;
                if (!r_ph) n_ph = 1'b1;
                else begin
                    n_ph = 1'b0;
                    n_head = r_head + CntW'(1);
                    n_rem = r_rem - CntW'(1);
                    if (s_rdeg == '0) n_state = S_PEEL_RD;
                    else begin
                        s_we = 1'b1; s_wdeg = '0; s_wxor = s_rxor;
                        n_a = s_rxor;
                        n_state = S_PEEL_PAR;
                    end
                end
            end
            S_PEEL_PAR: begin
                s_addr = r_a;
                if (!r_ph) n_ph = 1'b1;
                else begin
                    n_ph = 1'b0;
                    if (s_rdeg != '0) begin
                        s_we = 1'b1;
                        s_wdeg = s_rdeg - CntW'(1);
                        s_wxor = s_rxor ^ r_leaf;
                        if (s_rdeg == CntW'(2)) begin
                            q_we = 1'b1; q_wdata = r_a;
                            n_tail = r_tail + CntW'(1);
                        end
                    end
                    n_state = S_PEEL_RD;
                end
            end
            S_FINAL: begin
                // read the one or two survivors
                q_raddr = r_ph ? r_head[NodeW-1:0] + NodeW'(1) : r_head[NodeW-1:0];
                if (!r_bad && r_ncount != CntW'(1)) begin
                    if (r_rem > CntW'(2) || (r_tail - r_head) != r_rem ||
                        r_tail == r_head)
                        n_bad = 1'b1;
                end
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_c0 = q_rdata;
                    n_ph = 1'b0;
                    n_state = S_OUT0;
                end
                if (r_ph) n_idx = CntW'(0);
            end
            S_OUT0: begin
                q_raddr = r_head[NodeW-1:0] + NodeW'(1);
                n_c1 = q_rdata;
                n_state = S_OUT1;
            end
            S_OUT1: begin
                out_ch.valid = 1'b1;
                if (r_bad) begin
                    out_ch.data = '{center_node: '0, last: 1'b1, error: 1'b1};
                end else if (r_ncount == CntW'(1)) begin
                    out_ch.data = '{center_node: '0, last: 1'b1, error: 1'b0};
                end else if (r_rem == CntW'(1)) begin
                    out_ch.data = '{center_node: r_c0, last: 1'b1, error: 1'b0};
                end else if (!r_ph) begin
                    out_ch.data = '{center_node: (r_c1 < r_c0) ? r_c1 : r_c0,
                                    last: 1'b0, error: 1'b0};
                end else begin
                    out_ch.data = '{center_node: (r_c1 < r_c0) ? r_c0 : r_c1,
                                    last: 1'b1, error: 1'b0};
                end
                if (out_ch.ready) begin
                    if (out_ch.data.last) begin
                        n_ph = 1'b0; n_idx = '0; n_state = S_CLEAR;
                    end else n_ph = 1'b1;
                end
            end
            S_CLEAR: begin
                // clearing pass over the node store
                s_we = 1'b1; s_addr = r_idx[NodeW-1:0];
                n_idx = r_idx + CntW'(1);
                n_edges = '0; n_fault = 1'b0;
                if (r_idx == CntW'(MaxNodes - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // results only leave the block during the result state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> r_state == S_OUT1)
        else $error("result outside result state");

    // no item taken while a run is in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == S_IDLE)
        else $error("ready outside idle");

    // an error result always reports center zero and is the last
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.data.error) |->
        (out_ch.data.last && out_ch.data.center_node == '0))
        else $error("malformed error result");
endmodule

>>> tb/tb_tree_center_leaf_peeler_if.sv
// the testbench drives the channel interfaces declared with the rtl

>>> tb/tb_tree_center_leaf_peeler.sv
module tb_tree_center_leaf_peeler
    import tclp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [CntW-1:0] cfg_wdata;

    tclp_in_if  in_ch ();
    tclp_out_if out_ch ();

    tree_center_leaf_peeler DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    localparam int WatchLimit = 40000;
    localparam int InW        = $bits(t_in_item);
    localparam int DueDepth   = 8;

    // predictor state
    logic [CntW-1:0]  node_count_q;
    logic [CntW-1:0]  deg_q [MaxNodes];
    logic [NodeW-1:0] nxor_q [MaxNodes];
    logic [NodeW-1:0] leafq [MaxNodes];
    logic [CntW-1:0]  edges_q;
    logic             fault_q;

    // expected results, written at due_wr and taken at due_rd
    t_out_item centers_due [DueDepth];
    int  due_wr;
    int  due_rd;
    int  mismatch_cnt;
    int  idle_cycles;
    bit  timed_out;
    bit  in_raised;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic clear_pred();
        for (int i = 0; i < MaxNodes; i++) begin
            deg_q[i]  = '0;
            nxor_q[i] = '0;
        end
        edges_q = '0;
        fault_q = 1'b0;
    endtask

    function automatic t_out_item mk(logic [NodeW-1:0] c, logic l, logic e);
        t_out_item r;
        r.center_node = c;
        r.last        = l;
        r.error       = e;
        return r;
    endfunction

    function automatic void due_put(t_out_item v);
        centers_due[due_wr % DueDepth] = v;
        due_wr++;
    endfunction

    // expected centers for one accepted item
    task automatic predict_centers(t_in_item it);
        int  n, head, tail, rem, lend, lf, par;
        bit  bad;
        logic [NodeW-1:0] c0, c1, tmp;
        n = int'(node_count_q);
        head = 0;
        tail = 0;
        if (!it.mode) begin
            if (deg_q[it.node_a] != CntMax) deg_q[it.node_a]++;
            if (deg_q[it.node_b] != CntMax) deg_q[it.node_b]++;
            nxor_q[it.node_a] ^= it.node_b;
            nxor_q[it.node_b] ^= it.node_a;
            if (edges_q != CntMax) edges_q++;
            return;
        end
        bad = fault_q || n == 0 || n > MaxNodes;
        if (!bad && edges_q != n - 1) bad = 1;
        if (!bad)
            for (int i = n; i < MaxNodes; i++)
                if (deg_q[i] != 0) bad = 1;
        if (!bad && n == 1) begin
            clear_pred();
            due_put(mk('0, 1'b1, 1'b0));
            return;
        end
        rem = n;
        if (!bad) begin
            for (int i = 0; i < n; i++)
                if (deg_q[i] == 1 && tail < MaxNodes) leafq[tail++] = NodeW'(i);
            while (head < tail && rem > 2) begin
                lend = tail;
                while (head < lend) begin
                    lf = int'(leafq[head++]);
                    rem--;
                    if (deg_q[lf] == 0) continue;
                    deg_q[lf] = '0;
                    par = int'(nxor_q[lf]);
                    if (deg_q[par] > 0) begin
                        deg_q[par]--;
                        nxor_q[par] ^= lf[NodeW-1:0];
                        if (deg_q[par] == 1 && tail < MaxNodes)
                            leafq[tail++] = NodeW'(par);
                    end
                end
            end
            if (rem > 2 || (tail - head) != rem || tail == head) bad = 1;
        end
        clear_pred();
        if (bad) begin
            due_put(mk('0, 1'b1, 1'b1));
        end else if (tail - head == 1) begin
            due_put(mk(leafq[head], 1'b1, 1'b0));
        end else begin
            c0 = leafq[head];
            c1 = leafq[head + 1];
            if (c1 < c0) begin
                tmp = c0;
                c0  = c1;
                c1  = tmp;
            end
            due_put(mk(c0, 1'b0, 1'b0));
            due_put(mk(c1, 1'b1, 1'b0));
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    // random sink stall and result check
    initial begin
        int stall;
        t_out_item want;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk iff out_ch.valid);
            if (due_wr == due_rd) begin
                report_mismatch("result with no expectation");
            end else begin
                want = centers_due[due_rd % DueDepth];
                due_rd++;
                if (out_ch.data.center_node !== want.center_node)
                    report_mismatch($sformatf("center %0d want %0d",
                        out_ch.data.center_node, want.center_node));
                if (out_ch.data.last !== want.last)
                    report_mismatch($sformatf("last %0b want %0b",
                        out_ch.data.last, want.last));
                if (out_ch.data.error !== want.error)
                    report_mismatch($sformatf("error %0b want %0b",
                        out_ch.data.error, want.error));
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit && !timed_out) begin
            timed_out <= 1'b1;
            $display("tree_center_leaf_peeler test failed");
            $finish;
        end
    end

    // drop the input after its last transfer
    task automatic lower_input();
        if (in_raised) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= InW'($urandom);
            in_raised = 1'b0;
        end
    endtask

    // one item transfer
    task automatic send_item(logic md, logic [NodeW-1:0] a, logic [NodeW-1:0] b);
        t_in_item it;
        int gap;
        it.mode   = md;
        it.node_a = a;
        it.node_b = b;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            lower_input();
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        in_raised = 1'b1;
        @(posedge i_clk iff in_ch.ready);
        predict_centers(it);
    endtask

    task automatic wait_drain();
        lower_input();
        while (due_wr != due_rd) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    // register write once the block is idle
    task automatic set_node_count(int n);
        lower_input();
        @(posedge i_clk);
        while (due_wr != due_rd || !in_ch.ready) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n[CntW-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        node_count_q = n[CntW-1:0];
    endtask

    task automatic send_edge(int a, int b);
        send_item(1'b0, a[NodeW-1:0], b[NodeW-1:0]);
    endtask

    task automatic send_run();
        send_item(1'b1, NodeW'($urandom), NodeW'($urandom));
    endtask

    // random labelled tree, optionally broken
    task automatic send_tree(int n, bit damage);
        int perm [];
        int j, t, p, kind;
        perm = new[n];
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        kind = damage ? $urandom_range(0, 3) : 9;
        for (int i = 1; i < n; i++) begin
            p = $urandom_range(0, i - 1);
            if (kind == 0 && i == n - 1) send_edge(perm[i], perm[i]);
            else if (kind == 1 && i == n - 1) send_edge(perm[i], perm[i - 1 > 0 ? 1 : 0]);
            else if ($urandom_range(0, 1)) send_edge(perm[i], perm[p]);
            else send_edge(perm[p], perm[i]);
        end
        if (kind == 2 && n > 1) send_edge(perm[0], perm[n - 1]);
        if (kind == 3) send_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
        send_run();
    endtask

    task automatic test_single_node();
        set_node_count(1);
        send_run();
        send_edge(0, 0);
        send_run();
        wait_drain();
    endtask

    task automatic test_small_paths();
        set_node_count(2);
        send_edge(1, 0);
        send_run();
        set_node_count(3);
        send_edge(0, 1);
        send_edge(1, 2);
        send_run();
        set_node_count(4);
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 3);
        send_run();
        wait_drain();
    endtask

    task automatic test_bad_inputs();
        // zero count, oversize count, wrong edge count, out-of-range endpoint
        set_node_count(0);
        send_run();
        set_node_count(2047);
        send_edge(1023, 1023);
        send_run();
        set_node_count(1025);
        send_run();
        set_node_count(4);
        send_edge(0, 1);
        send_run();
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(2, 1023);
        send_run();
        // cycle plus repeated edge
        set_node_count(4);
        send_edge(0, 1);
        send_edge(1, 0);
        send_edge(2, 3);
        send_run();
        wait_drain();
    endtask

    task automatic test_full_size();
        set_node_count(1024);
        send_tree(1024, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_trees();
        int sent, n;
        sent = 0;
        while (sent < 100) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            set_node_count(n);
            if ($urandom_range(0, 15) == 0) begin
                for (int k = $urandom_range(0, 3); k > 0; k--)
                    send_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
                send_run();
            end else begin
                send_tree(n, $urandom_range(0, 4) == 0);
            end
            sent += n + 1;
            wait_drain();
        end
    endtask

    initial begin
        mismatch_cnt = 0;
        idle_cycles  = 0;
        timed_out    = 1'b0;
        in_raised    = 1'b0;
        due_wr       = 0;
        due_rd       = 0;
        node_count_q = 1;
        clear_pred();
        i_rst_n     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (1100) @(posedge i_clk);
        test_single_node();
        test_small_paths();
        test_bad_inputs();
        test_full_size();
        test_random_trees();
        if (mismatch_cnt == 0)
            $display("tree_center_leaf_peeler test passed");
        else
            $display("tree_center_leaf_peeler test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/tclp_pkg.sv
rtl/tclp_if.sv
rtl/tclp_store.sv
rtl/tclp_queue.sv
rtl/tree_center_leaf_peeler.sv
tb/tb_tree_center_leaf_peeler_if.sv
tb/tb_tree_center_leaf_peeler.sv
